[src/sao_pkg.sv]
// Package: widths, angle constants and the step result type for the steering angle optimizer.
`timescale 1ns / 1ps
`default_nettype none

package sao_pkg;

   // Fixed-point format: FRAC_BITS fraction bits per degree
   localparam int FRAC_BITS = 6;

   // Field widths
   localparam int TGT_W = 16;
   localparam int ACC_W = 18;
   localparam int DLT_W = 17;

   // Internal working width for sums of angle values
   localparam int WORK_W = ACC_W + 6;

   // Angle constants in fixed-point units
   localparam int DEG90   = 90 << FRAC_BITS;
   localparam int DEG180  = 180 << FRAC_BITS;
   localparam int DEG360  = 360 << FRAC_BITS;
   localparam int DEG1080 = 1080 << FRAC_BITS;

   // Largest whole number of turns an accumulator magnitude can hold
   localparam int MOD_STEPS = (1 << (ACC_W - 1)) / DEG360;

   typedef logic signed [TGT_W-1:0]  target_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [DLT_W-1:0]  delta_type;
   typedef logic signed [WORK_W-1:0] work_type;

   // Outcome of one step, passed from the datapath to the control
   typedef struct packed {
      logic    changed;
      acc_type acc_next;
      delta_type delta;
   } step_result_type;

endpackage

`default_nettype wire

[src/sao_if.sv]
// Interfaces: request and response channels of the steering angle optimizer.
`timescale 1ns / 1ps
`default_nettype none

interface sao_req_if;
   import sao_pkg::*;

   logic       valid;
   logic       ready;
   target_type target_angle;

   modport source (output valid, output target_angle, input ready);
   modport sink (input valid, input target_angle, output ready);
endinterface

interface sao_rsp_if;
   import sao_pkg::*;

   logic      valid;
   logic      ready;
   acc_type   optimized_angle;
   delta_type applied_delta;

   modport source (output valid, output optimized_angle, output applied_delta, input ready);
   modport sink (input valid, input optimized_angle, input applied_delta, output ready);
endinterface

`default_nettype wire

[src/sao_step.sv]
// Datapath: one optimization step from the held target and the current wheel state.
`timescale 1ns / 1ps
`default_nettype none

module sao_step
   import sao_pkg::*;
(
   input  target_type      target_angle,
   input  acc_type         acc,
   input  target_type      prev_target,
   output step_result_type result
);

   work_type acc_w;
   work_type tgt_w;
   work_type mag;
   work_type rem;
   work_type acc_mod;
   work_type cal;
   work_type delta;
   work_type sum;

   always_comb begin
      acc_w = WORK_W'(acc);
      tgt_w = WORK_W'(target_angle);

      // Reduce the accumulator modulo one turn, truncating toward zero
      mag = acc_w[WORK_W-1] ? -acc_w : acc_w;
      rem = mag;
      for (int k = 1; k <= MOD_STEPS; k++) begin
         if (mag >= WORK_W'(k * DEG360)) begin
            rem = mag - WORK_W'(k * DEG360);
         end
      end
      acc_mod = acc_w[WORK_W-1] ? -rem : rem;

      // Move the target by one turn so its sign matches the accumulator
      cal = tgt_w;
      if (!acc_w[WORK_W-1] && tgt_w[WORK_W-1]) begin
         cal = tgt_w + WORK_W'(DEG360);
      end else if (acc_w[WORK_W-1] && (tgt_w > 0)) begin
         cal = tgt_w - WORK_W'(DEG360);
      end

      // Wrap the difference once toward +-180
      delta = cal - acc_mod;
      if (delta > WORK_W'(DEG180)) begin
         delta = delta - WORK_W'(DEG360);
      end else if (delta < -WORK_W'(DEG180)) begin
         delta = delta + WORK_W'(DEG360);
      end

      // Fold into +-90 by reversing the wheel
      if ((delta > WORK_W'(DEG90)) && (delta <= WORK_W'(DEG180))) begin
         delta = delta - WORK_W'(DEG180);
      end else if ((delta < -WORK_W'(DEG90)) && (delta >= -WORK_W'(DEG180))) begin
         delta = delta + WORK_W'(DEG180);
      end

      // Apply and pull the accumulator back by one turn at +-1080
      sum = acc_w + delta;
      if (sum >= WORK_W'(DEG1080)) begin
         sum = sum - WORK_W'(DEG360);
      end else if (sum <= -WORK_W'(DEG1080)) begin
         sum = sum + WORK_W'(DEG360);
      end

      // Unchanged target keeps the state and reports no rotation
      result.changed = (target_angle != prev_target);
      if (result.changed) begin
         result.acc_next = sum[ACC_W-1:0];
         result.delta    = delta[DLT_W-1:0];
      end else begin
         result.acc_next = acc;
         result.delta    = '0;
      end
   end

endmodule

`default_nettype wire

[src/steer_angle_optimizer.sv]
// Top level: input register, wheel state, step datapath and result register.
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    target_angle    (16 b signed, 1/64 deg)
//   rsp_chan  out   valid/ready    optimized_angle (18 b signed), applied_delta (17 b signed)
//
// One result per request, taken through the input register and then the output register.
// A new request is taken every cycle unless the result side stalls; the accumulator feedback
// runs from the wheel-state register through the step datapath, which sets that rate.
// Reset (synchronous) clears the accumulated angle, the previous target and both valids.
// A stalled result holds in the output register; the input register refills behind it.
`timescale 1ns / 1ps
`default_nettype none

module steer_angle_optimizer
   import sao_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   sao_req_if.sink     req_chan,
   sao_rsp_if.source   rsp_chan
);

   logic            in_valid_ff, in_valid_in;
   target_type      in_target_ff, in_target_in;
   logic            out_valid_ff, out_valid_in;
   acc_type         out_acc_ff, out_acc_in;
   delta_type       out_delta_ff, out_delta_in;
   acc_type         acc_ff, acc_in;
   target_type      prev_ff, prev_in;
   logic            advance;
   logic            take;
   step_result_type step;

   sao_step u_step (
      .target_angle (in_target_ff),
      .acc          (acc_ff),
      .prev_target  (prev_ff),
      .result       (step)
   );

   // Handshake: advance the held item when the output register is free
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   // Next values of the input register, state and output register
   always_comb begin
      in_valid_in  = take || (in_valid_ff && !advance);
      in_target_in = take ? req_chan.target_angle : in_target_ff;

      acc_in  = acc_ff;
      prev_in = prev_ff;
      if (advance && step.changed) begin
         acc_in  = step.acc_next;
         prev_in = in_target_ff;
      end

      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      out_acc_in   = advance ? step.acc_next : out_acc_ff;
      out_delta_in = advance ? step.delta : out_delta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         prev_ff      <= prev_in;
      end
      in_target_ff <= in_target_in;
      out_acc_ff   <= out_acc_in;
      out_delta_ff <= out_delta_in;
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.optimized_angle = out_acc_ff;
   assign rsp_chan.applied_delta   = out_delta_ff;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Testbench: directed and random steering targets checked against a wheel-angle predictor.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import sao_pkg::*;

   localparam int RANDOM_ITEMS = 1450;
   localparam int TAIL_CYCLES  = 8;

   typedef struct {
      acc_type   acc;
      delta_type dlt;
   } wheel_result_type;

   typedef struct {
      target_type target;
      bit         known;
      acc_type    acc;
      delta_type  dlt;
   } target_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sao_req_if req_chan ();
   sao_rsp_if rsp_chan ();

   steer_angle_optimizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: wheel angle and last target seen
   acc_type    wheel_angle;
   target_type last_target;

   wheel_result_type pending_results[$];
   int  mismatches = 0;
   bit  calm = 1'b0;

   target_row_type directed_rows [22];

   always #2 clock = ~clock;

   // Work out the wheel angle and rotation that one target causes
   function automatic void step_wheel(input target_type tgt, output wheel_result_type res);
      longint t, cal, dl, acc_l, sum;
      t = tgt;
      dl = 0;
      if (tgt != last_target) begin
         acc_l = wheel_angle;
         cal = t;
         if (acc_l >= 0 && cal < 0)
            cal = cal + DEG360;
         else if (acc_l < 0 && cal > 0)
            cal = cal - DEG360;
         dl = cal - (acc_l - (acc_l / DEG360) * DEG360);
         // wrap once toward +-180
         if (dl > DEG180)
            dl = dl - DEG360;
         else if (dl < -DEG180)
            dl = dl + DEG360;
         // fold into +-90 by reversing the wheel
         if (dl > DEG90 && dl <= DEG180)
            dl = dl - DEG180;
         else if (dl < -DEG90 && dl >= -DEG180)
            dl = dl + DEG180;
         last_target = tgt;
         sum = acc_l + dl;
         if (sum >= DEG1080)
            sum = sum - DEG360;
         else if (sum <= -DEG1080)
            sum = sum + DEG360;
         wheel_angle = acc_type'(sum);
      end
      res.acc = wheel_angle;
      res.dlt = delta_type'(dl);
   endfunction

   // Offer one target, idling at random first; hold until the transfer
   task automatic drive_target(input target_type tgt, input bit known,
                               input acc_type k_acc, input delta_type k_dlt);
      wheel_result_type res;
      while (!calm && $urandom_range(99) < 23) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.target_angle <= tgt;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      step_wheel(tgt, res);
      if (known) begin
         res.acc = k_acc;
         res.dlt = k_dlt;
      end
      pending_results.push_back(res);
      @(negedge clock);
   endtask

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= 23);
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      wheel_result_type exp_res;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: optimized_angle %0d applied_delta %0d",
                   rsp_chan.optimized_angle, rsp_chan.applied_delta);
            mismatches++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_chan.optimized_angle !== exp_res.acc) begin
               $error("optimized_angle: expected %0d, actual %0d",
                      exp_res.acc, rsp_chan.optimized_angle);
               mismatches++;
            end
            if (rsp_chan.applied_delta !== exp_res.dlt) begin
               $error("applied_delta: expected %0d, actual %0d",
                      exp_res.dlt, rsp_chan.applied_delta);
               mismatches++;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int sent;
      int kind;
      int seq_len;
      int phase;
      int stride;
      int t;
      target_type prev_tgt;

      req_chan.valid        = 1'b0;
      req_chan.target_angle = '0;
      rsp_chan.ready        = 1'b0;
      wheel_angle = '0;
      last_target = '0;

      // Known rows: reset value, a quarter turn, then the same target again
      directed_rows = '{
         '{16'sd0,      1'b1, 18'sd0,    17'sd0},
         '{16'sd5760,   1'b1, 18'sd5760, 17'sd5760},
         '{16'sd5760,   1'b1, 18'sd5760, 17'sd0},
         '{16'sd5761,   1'b0, 18'sd0,    17'sd0},
         '{16'sd11520,  1'b0, 18'sd0,    17'sd0},
         '{16'sd11521,  1'b0, 18'sd0,    17'sd0},
         '{-16'sd5760,  1'b0, 18'sd0,    17'sd0},
         '{-16'sd11520, 1'b0, 18'sd0,    17'sd0},
         '{16'sd17280,  1'b0, 18'sd0,    17'sd0},
         '{-16'sd17280, 1'b0, 18'sd0,    17'sd0},
         '{16'sd23040,  1'b0, 18'sd0,    17'sd0},
         '{-16'sd23040, 1'b0, 18'sd0,    17'sd0},
         '{-16'sd23040, 1'b0, 18'sd0,    17'sd0},
         '{16'sd32767,  1'b0, 18'sd0,    17'sd0},
         '{16'sh8000,   1'b0, 18'sd0,    17'sd0},
         '{16'sd1,      1'b0, 18'sd0,    17'sd0},
         '{-16'sd1,     1'b0, 18'sd0,    17'sd0},
         '{16'sd21845,  1'b0, 18'sd0,    17'sd0},
         '{-16'sd21846, 1'b0, 18'sd0,    17'sd0},
         '{16'sd10922,  1'b0, 18'sd0,    17'sd0},
         '{16'sd0,      1'b0, 18'sd0,    17'sd0},
         '{16'sd0,      1'b0, 18'sd0,    17'sd0}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         drive_target(directed_rows[i].target, directed_rows[i].known,
                      directed_rows[i].acc, directed_rows[i].dlt);

      sent = 0;
      prev_tgt = '0;
      while (sent < RANDOM_ITEMS) begin
         kind = $urandom_range(99);
         if (kind < 55) begin
            // Sweep the target around the circle so the wheel angle winds up
            seq_len = $urandom_range(40, 5);
            phase   = $urandom_range(2 * DEG360) - DEG360;
            stride  = $urandom_range(DEG90);
            if ($urandom_range(1))
               stride = -stride;
            for (int k = 0; k < seq_len; k++) begin
               if ($urandom_range(9) != 0)
                  phase = phase + stride + $urandom_range(128) - 64;
               t = phase % DEG360;
               if (t > 0 && $urandom_range(3) == 0)
                  t = t - DEG360;
               else if (t < 0 && $urandom_range(3) == 0)
                  t = t + DEG360;
               prev_tgt = target_type'(t);
               drive_target(prev_tgt, 1'b0, '0, '0);
               sent++;
               calm = (sent >= 500 && sent < 800);
            end
         end else begin
            if (kind < 70)
               // probe the fold and wrap edges
               t = ($urandom_range(8) - 4) * DEG90 + $urandom_range(4) - 2;
            else if (kind < 85)
               t = $urandom_range(2 * DEG360) - DEG360;
            else if (kind < 95)
               t = target_type'($urandom);
            else
               t = prev_tgt;
            prev_tgt = target_type'(t);
            drive_target(prev_tgt, 1'b0, '0, '0);
            sent++;
            calm = (sent >= 500 && sent < 800);
         end
      end

      req_chan.valid <= 1'b0;
      calm = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #400000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
